// ===== design/sm3_pkg.sv =====
package sm3_pkg;

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] T_LO = 32'h79CC4519;
  localparam logic [31:0] T_HI = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_AT = 6'd56;
  localparam int          BLOCK_BYTES = 64;
  localparam int          ROUNDS = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_EMIT
  } state_t;

  // compression unit control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } cmp_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== design/sm3_if.sv =====
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;
  modport source (output valid, data_byte, has_byte, last_byte, input ready);
  modport sink (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/sm3_round.sv =====
// One SM3 round per cycle over the 64 rounds; schedule word fed from a 16-entry window.
module sm3_round (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      chain [8],
  input  logic [511:0]     block,
  output logic             done,
  output logic [31:0]      regs [8]
);

  logic [31:0] w [16];
  logic [31:0] w_next_word;
  logic [5:0]  j;
  logic        busy;
  logic [31:0] wj, wp, tj, a12, ss1, ss2, ff, gg, tt1, tt2;

  // window is kept shifted so w[0] is W[j]
  always_comb begin
    w_next_word = sm3_pkg::p1(w[0] ^ w[7] ^ sm3_pkg::rotl(w[13], 5'd15)) ^
                  sm3_pkg::rotl(w[3], 5'd7) ^ w[10];
    wj  = w[0];
    wp  = w[0] ^ w[4];
    tj  = (j < 6'd16) ? sm3_pkg::T_LO : sm3_pkg::T_HI;
    a12 = sm3_pkg::rotl(regs[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + regs[4] + sm3_pkg::rotl(tj, j[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j < 6'd16) begin
      ff = regs[0] ^ regs[1] ^ regs[2];
      gg = regs[4] ^ regs[5] ^ regs[6];
    end else begin
      ff = (regs[0] & regs[1]) | (regs[0] & regs[2]) | (regs[1] & regs[2]);
      gg = (regs[4] & regs[5]) | (~regs[4] & regs[6]);
    end
    tt1 = ff + regs[3] + ss2 + wp;
    tt2 = gg + regs[7] + ss1 + wj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      j    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        j    <= '0;
      end else if (busy) begin
        j <= j + 6'd1;
        if (j == 6'(sm3_pkg::ROUNDS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int k = 0; k < 16; k++) w[k] <= block[511 - 32*k -: 32];
      for (int k = 0; k < 8; k++) regs[k] <= chain[k];
    end else if (busy) begin
      for (int k = 0; k < 15; k++) w[k] <= w[k+1];
      w[15]   <= w_next_word;
      regs[3] <= regs[2];
      regs[2] <= sm3_pkg::rotl(regs[1], 5'd9);
      regs[1] <= regs[0];
      regs[0] <= tt1;
      regs[7] <= regs[6];
      regs[6] <= sm3_pkg::rotl(regs[5], 5'd19);
      regs[5] <= regs[4];
      regs[4] <= sm3_pkg::p0(tt2);
    end
  end

  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without round run");
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    (busy && j != 6'(sm3_pkg::ROUNDS - 1)) |=> busy) else $error("early stop");
  a_start: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && j == 6'd0) else $error("start not taken");

endmodule

// ===== design/sm3_message_digest_unit.sv =====
// SM3 hash unit, byte-serial input.
// in:  sm3_in_if sink. Each item carries data_byte, has_byte and last_byte.
//      has_byte=1 appends data_byte; last_byte=1 closes the message (an
//      item with has_byte=0, last_byte=1 closes it with no new byte).
// out: sm3_out_if source. Eight 32-bit digest words, word_index 0..7,
//      last_word on word 7, big-endian.
// Timing: a plain byte is accepted in idle and ready stays high. A
// compression runs load, 64 rounds, the done flag and fold on the single
// shared round unit running one round per cycle. A byte that fills the
// 64-byte block holds ready low for the whole compression. A final item
// spends a padding step before each of its one or two compressions (plus
// one more compression when its byte also completes a block), then emits
// the eight words at one per cycle while out.ready is high.
// Ready is low while padding, a compression or the digest emission is in progress.
// Receiver stall: the current digest word holds on the port until taken;
// nothing is lost. After the eighth word the chaining value returns to
// the initial value and the block takes the next message.
// Reset (rst, synchronous): chaining value = IV, fill position and bit
// count cleared, outputs invalid. No clearing pass needed.
module sm3_message_digest_unit (
  input logic      clk,
  input logic      rst,
  sm3_in_if.sink   in,
  sm3_out_if.source out
);

  sm3_pkg::state_t state, state_next;

  logic [31:0] chain [8];
  logic [31:0] blk_word [16];  // block buffer, four bytes per entry, big-endian
  logic [31:0] pad_word [16];
  logic [5:0]  fill;
  logic [63:0] bits;
  logic        fin;       // in final padding sequence
  logic        second;    // length block still to compress
  logic        padded;    // padding already built for this message
  logic [2:0]  widx;

  logic [511:0] block;
  logic         cmp_done;
  logic [31:0]  regs [8];
  logic         accept;

  assign accept = in.valid && in.ready;

  always_comb begin
    for (int k = 0; k < 16; k++) block[511 - 32*k -: 32] = blk_word[k];
  end

  sm3_round u_round (
    .clk(clk), .rst(rst), .start(state == sm3_pkg::S_LOAD),
    .chain(chain), .block(block), .done(cmp_done), .regs(regs)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sm3_pkg::S_IDLE: begin
        if (accept) begin
          if (in.has_byte && fill == 6'd63) state_next = sm3_pkg::S_LOAD;
          else if (in.last_byte) state_next = sm3_pkg::S_PAD;
        end
      end
      sm3_pkg::S_PAD:   state_next = sm3_pkg::S_LOAD;
      sm3_pkg::S_LOAD:  state_next = sm3_pkg::S_ROUND;
      sm3_pkg::S_ROUND: if (cmp_done) state_next = sm3_pkg::S_FOLD;
      sm3_pkg::S_FOLD: begin
        // a final byte that completed a block still needs its padding block
        if (second) state_next = sm3_pkg::S_PAD;
        else if (fin) state_next = padded ? sm3_pkg::S_EMIT : sm3_pkg::S_PAD;
        else state_next = sm3_pkg::S_IDLE;
      end
      sm3_pkg::S_EMIT:
        if (out.ready && widx == 3'd7) state_next = sm3_pkg::S_IDLE;
      default: state_next = sm3_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in.ready        = (state == sm3_pkg::S_IDLE);
    out.valid       = (state == sm3_pkg::S_EMIT);
    out.digest_word = chain[widx];
    out.word_index  = widx;
    out.last_word   = (widx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sm3_pkg::S_IDLE;
    else     state <= state_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      bits   <= '0;
      fin    <= 1'b0;
      second <= 1'b0;
      padded <= 1'b0;
      widx   <= '0;
      for (int k = 0; k < 8; k++) chain[k] <= sm3_pkg::IV[k];
    end else begin
      unique case (state)
        sm3_pkg::S_IDLE: begin
          if (accept) begin
            if (in.has_byte) begin
              fill <= fill + 6'd1;
              bits <= bits + 64'd8;
            end
            fin <= in.last_byte;
          end
        end
        sm3_pkg::S_PAD: begin
          // second pass: length block after an overflow block
          second <= (!second) && (fill > 6'd55);
          padded <= 1'b1;
        end
        sm3_pkg::S_FOLD: begin
          for (int k = 0; k < 8; k++) chain[k] <= chain[k] ^ regs[k];
          if (fin && !second) fill <= '0;
        end
        sm3_pkg::S_EMIT: begin
          if (out.ready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              for (int k = 0; k < 8; k++) chain[k] <= sm3_pkg::IV[k];
              bits   <= '0;
              fin    <= 1'b0;
              padded <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // padded block: 0x80 at the fill position, zeros after it, length in the
  // last 8 bytes when it fits; the length-only block after an overflow
  // block is zeros then length
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      for (int l = 0; l < 4; l++) begin
        if (second) begin
          if (6'(4*i + l) < sm3_pkg::LEN_AT) pad_word[i][31 - 8*l -: 8] = 8'h00;
          else pad_word[i][31 - 8*l -: 8] = bits[8*(63 - 4*i - l) +: 8];
        end else if (6'(4*i + l) == fill) begin
          pad_word[i][31 - 8*l -: 8] = sm3_pkg::PAD_BYTE;
        end else if (6'(4*i + l) < fill) begin
          pad_word[i][31 - 8*l -: 8] = blk_word[i][31 - 8*l -: 8];
        end else if (fill < sm3_pkg::LEN_AT && 6'(4*i + l) >= sm3_pkg::LEN_AT) begin
          pad_word[i][31 - 8*l -: 8] = bits[8*(63 - 4*i - l) +: 8];
        end else begin
          pad_word[i][31 - 8*l -: 8] = 8'h00;
        end
      end
    end
  end

  // block buffer
  always_ff @(posedge clk) begin
    if (state == sm3_pkg::S_IDLE && accept && in.has_byte) begin
      blk_word[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= in.data_byte;
    end else if (state == sm3_pkg::S_PAD) begin
      for (int i = 0; i < 16; i++) blk_word[i] <= pad_word[i];
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    (state != sm3_pkg::S_IDLE) |-> !in.ready) else $error("ready while busy");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> out.valid && $stable(widx))
    else $error("digest word dropped");
  a_fill_clear: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> fill == 6'd0) else $error("fill not cleared at emit");
  a_emit_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(out.valid) |-> widx == 3'd0) else $error("emit not at word 0");

endmodule
